### rtl/e2r_pkg.sv
// Shared types, widths and the CORDIC arctangent table for the Euler-to-DCM block.
package e2r_pkg;

  // Input transaction: three binary angles, 32768 counts = pi
  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
  } in_t;

  // Output transaction: nine matrix entries, Q1.14
  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } out_t;

  localparam int OUT_W     = 16;
  localparam int WORK_FRAC = 30;
  localparam int TABLE_LEN = 24;
  localparam int XW = 33;          // CORDIC x/y, Q30 with headroom
  localparam int ZW = 34;          // residual angle, 2^32 = one turn
  localparam int MW = 34;          // rounded sr*sp and cr*sp, Q30
  localparam int PW = MW + XW;     // Q60 products
  localparam int SW = PW + 2;      // Q60 sums

  localparam logic signed [XW-1:0] CORDIC_GAIN_INIT = XW'(652032874);

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] t;
    unique case (i)
      0:  t = 32'h20000000;
      1:  t = 32'h12E4051E;
      2:  t = 32'h09FB385B;
      3:  t = 32'h051111D4;
      4:  t = 32'h028B0D43;
      5:  t = 32'h0145D7E1;
      6:  t = 32'h00A2F61E;
      7:  t = 32'h00517C55;
      8:  t = 32'h0028BE53;
      9:  t = 32'h00145F2F;
      10: t = 32'h000A2F98;
      11: t = 32'h000517CC;
      12: t = 32'h00028BE6;
      13: t = 32'h000145F3;
      14: t = 32'h0000A2FA;
      15: t = 32'h0000517D;
      16: t = 32'h000028BE;
      17: t = 32'h0000145F;
      18: t = 32'h00000A30;
      19: t = 32'h00000518;
      20: t = 32'h0000028C;
      21: t = 32'h00000146;
      22: t = 32'h000000A3;
      23: t = 32'h00000051;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

### rtl/e2r_cordic.sv
// One sine/cosine lane: quadrant fold plus an unrolled, registered CORDIC pipeline.
module e2r_cordic
  import e2r_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int STAGES     = 16
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic signed [15:0]   angle,
  output logic signed [XW-1:0] cos_val,
  output logic signed [XW-1:0] sin_val
);

  logic [ANGLE_BITS-1:0] a_low;
  logic [31:0]           ang;
  logic                  flip0;
  logic signed [ZW-1:0]  z0;

  // place angle at top of a 32-bit turn word, fold quadrants 1 and 2 by pi
  assign a_low = ANGLE_BITS'($unsigned(angle));
  assign ang   = {a_low, {(32 - ANGLE_BITS){1'b0}}};
  assign flip0 = ang[31] ^ ang[30];
  assign z0    = ZW'(signed'({ang[31] ^ flip0, ang[30:0]}));

  logic signed [XW-1:0] xr [1:STAGES];
  logic signed [XW-1:0] yr [1:STAGES];
  logic signed [ZW-1:0] zr [1:STAGES];
  logic                 fr [1:STAGES];

  for (genvar gi = 0; gi < STAGES; gi++) begin : g_stage
    logic signed [XW-1:0] xi, yi, dx, dy;
    logic signed [ZW-1:0] zi, da;
    logic                 fi;

    if (gi == 0) begin : g_first
      assign xi = CORDIC_GAIN_INIT;
      assign yi = '0;
      assign zi = z0;
      assign fi = flip0;
    end else begin : g_rest
      assign xi = xr[gi];
      assign yi = yr[gi];
      assign zi = zr[gi];
      assign fi = fr[gi];
    end

    assign dx = yi >>> gi;
    assign dy = xi >>> gi;
    assign da = signed'({{(ZW - 32){1'b0}}, atan_turn(gi)});

    // rotate toward zero residual; zero counts as positive
    always_ff @(posedge clk) begin
      if (ce) begin
        if (!zi[ZW-1]) begin
          xr[gi+1] <= xi - dx;
          yr[gi+1] <= yi + dy;
          zr[gi+1] <= zi - da;
        end else begin
          xr[gi+1] <= xi + dx;
          yr[gi+1] <= yi - dy;
          zr[gi+1] <= zi + da;
        end
        fr[gi+1] <= fi;
      end
    end
  end

  // undo the quadrant fold
  assign cos_val = fr[STAGES] ? -xr[STAGES] : xr[STAGES];
  assign sin_val = fr[STAGES] ? -yr[STAGES] : yr[STAGES];

endmodule

### rtl/e2r_matrix.sv
// Merge stage: combines the three lanes' sines and cosines into the rotation matrix.
module e2r_matrix
  import e2r_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic signed [XW-1:0] cr,
  input  logic signed [XW-1:0] sr,
  input  logic signed [XW-1:0] cp,
  input  logic signed [XW-1:0] sp,
  input  logic signed [XW-1:0] cy,
  input  logic signed [XW-1:0] sy,
  output out_t                 res
);

  localparam int SH = 2 * WORK_FRAC - FRAC_BITS;
  localparam logic signed [SW-1:0] LIM  = SW'(1) <<< FRAC_BITS;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SH - 1);

  // stage 1: double products for the triple terms
  logic signed [2*XW-1:0] p_srsp, p_crsp;
  logic signed [XW-1:0]   cr1, sr1, cp1, sp1, cy1, sy1;
  always_ff @(posedge clk) begin
    if (ce) begin
      p_srsp <= sr * sp;
      p_crsp <= cr * sp;
      cr1 <= cr; sr1 <= sr; cp1 <= cp; sp1 <= sp; cy1 <= cy; sy1 <= sy;
    end
  end

  // stage 2: round back to Q30
  logic signed [2*XW-1:0] r_srsp, r_crsp;
  logic signed [MW-1:0]   srsp, crsp;
  logic signed [XW-1:0]   cr2, sr2, cp2, sp2, cy2, sy2;
  assign r_srsp = (p_srsp + ((2*XW)'(1) <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
  assign r_crsp = (p_crsp + ((2*XW)'(1) <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
  always_ff @(posedge clk) begin
    if (ce) begin
      srsp <= MW'(r_srsp);
      crsp <= MW'(r_crsp);
      cr2 <= cr1; sr2 <= sr1; cp2 <= cp1; sp2 <= sp1; cy2 <= cy1; sy2 <= sy1;
    end
  end

  // stage 3: Q60 products, full width from the register width
  logic signed [PW-1:0] srsp_cy, cr_sy, crsp_cy, sr_sy, cp_cy, cp_sy;
  logic signed [PW-1:0] srsp_sy, cr_cy, crsp_sy, sr_cy, sr_cp, cr_cp;
  logic signed [XW-1:0] sp3;
  always_ff @(posedge clk) begin
    if (ce) begin
      srsp_cy <= srsp * cy2;
      crsp_cy <= crsp * cy2;
      srsp_sy <= srsp * sy2;
      crsp_sy <= crsp * sy2;
      cr_sy   <= cr2 * sy2;
      sr_sy   <= sr2 * sy2;
      cp_cy   <= cp2 * cy2;
      cp_sy   <= cp2 * sy2;
      cr_cy   <= cr2 * cy2;
      sr_cy   <= sr2 * cy2;
      sr_cp   <= sr2 * cp2;
      cr_cp   <= cr2 * cp2;
      sp3     <= sp2;
    end
  end

  // stage 4: sums in Q60
  logic signed [SW-1:0] s [0:8];
  always_ff @(posedge clk) begin
    if (ce) begin
      s[0] <= SW'(cp_cy);
      s[1] <= SW'(srsp_cy) - SW'(cr_sy);
      s[2] <= SW'(crsp_cy) + SW'(sr_sy);
      s[3] <= SW'(cp_sy);
      s[4] <= SW'(srsp_sy) + SW'(cr_cy);
      s[5] <= SW'(crsp_sy) - SW'(sr_cy);
      s[6] <= -(SW'(sp3) <<< WORK_FRAC);
      s[7] <= SW'(sr_cp);
      s[8] <= SW'(cr_cp);
    end
  end

  // stage 5: round to FRAC_BITS, saturate to +-1.0, register the result
  logic [OUT_W-1:0] fin [0:8];
  for (genvar gk = 0; gk < 9; gk++) begin : g_fin
    logic signed [SW-1:0]    v, c;
    logic [FRAC_BITS+1:0]    m;
    assign v = (s[gk] + HALF) >>> SH;
    assign c = (v > LIM) ? LIM : ((v < -LIM) ? -LIM : v);
    assign m = c[FRAC_BITS+1:0];
    assign fin[gk] = OUT_W'(m);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      res.r00 <= fin[0];
      res.r01 <= fin[1];
      res.r02 <= fin[2];
      res.r10 <= fin[3];
      res.r11 <= fin[4];
      res.r12 <= fin[5];
      res.r20 <= fin[6];
      res.r21 <= fin[7];
      res.r22 <= fin[8];
    end
  end

endmodule

### rtl/euler_to_rotation_matrix_top.sv
// Top level: ZYX Euler angles to rotation matrix, three CORDIC lanes and a merge stage.
//
//  channel | direction | payload | handshake
//  in      | input     | in_t    | in_valid / in_ready
//  out     | output    | out_t   | out_valid / out_ready
//
//  One transaction per cycle sustained while results are taken; the pipeline is
//  CORDIC_STAGES (max 24) CORDIC registers, then the five merge-stage registers.
//  The whole pipeline advances together; it holds only while the output register
//  carries a transaction that out_ready has not taken.
//  Reset (rst, synchronous) clears the valid bits only; the datapath registers are not reset.
module euler_to_rotation_matrix_top
  import e2r_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int NS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int LAT = NS + 5;

  logic ce;
  logic [LAT-1:0] vld;

  // advance whenever the output register is empty or being drained
  assign ce        = !vld[LAT-1] || out_ready;
  assign in_ready  = ce;
  assign out_valid = vld[LAT-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  logic signed [XW-1:0] cr, sr, cp, sp, cy, sy;

  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(NS)) u_roll (
    .clk(clk), .ce(ce), .angle(in_data.roll_angle), .cos_val(cr), .sin_val(sr)
  );
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(NS)) u_pitch (
    .clk(clk), .ce(ce), .angle(in_data.pitch_angle), .cos_val(cp), .sin_val(sp)
  );
  e2r_cordic #(.ANGLE_BITS(ANGLE_BITS), .STAGES(NS)) u_yaw (
    .clk(clk), .ce(ce), .angle(in_data.yaw_angle), .cos_val(cy), .sin_val(sy)
  );

  e2r_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .ce(ce),
    .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .res(out_data)
  );

  // a stalled result keeps its transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // output empties when drained with nothing behind it
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !vld[LAT-2] |=> !out_valid)
    else $error("transaction duplicated at output");

  // input is blocked only by a full, stalled output
  a_block: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

  // an accepted transaction enters the pipeline
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted transaction lost");

endmodule
